FILE: src/assert_macros.svh
// Assertion macros for the segmented record translator RTL.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define AST_CHECK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("segmented record translator check failed");
`define AST_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("segmented record translator forbidden condition");
`else
`define AST_CHECK(lbl, clk, rstn, prop)
`define AST_NEVER(lbl, clk, rstn, expr)
`endif

`endif

FILE: src/srat_pkg.sv
// Types, codes and width helpers for the segmented record translator.
// Used by every module of the block; depends on nothing.
package srat_pkg;

	localparam int RecW = 24;
	localparam int AddrW = 48;
	localparam int SizeW = 16;
	localparam int CntW = 9;
	localparam int ByteW = 8;
	localparam int ProdW = RecW + SizeW;

	typedef enum logic [2:0] {
		OP_LOAD_DESC = 3'd0,
		OP_LOAD_BASE = 3'd1,
		OP_TRANSLATE = 3'd2,
		OP_ALLOCATE  = 3'd3,
		OP_SET_COUNT = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		STS_OK     = 3'd0,
		STS_RANGE  = 3'd1,
		STS_NODESC = 3'd2,
		STS_NOSEG  = 3'd3,
		STS_FULL   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_MAX_RECORDS = 2'd0,
		REG_RECORD_SIZE = 2'd1,
		REG_DESC_COUNT  = 2'd2,
		REG_BLOCK_COUNT = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_RD,
		S_CMP,
		S_MUL,
		S_ADD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [RecW-1:0]  max_records;
		logic [SizeW-1:0] record_size;
		logic [CntW-1:0]  desc_count;
		logic [CntW-1:0]  block_count;
	} cfg_t;

	typedef struct packed {
		logic [RecW-1:0]  first;
		logic [RecW-1:0]  last;
		logic [ByteW-1:0] block;
		logic [AddrW-1:0] offset;
	} desc_t;

	typedef struct packed {
		status_t          status;
		logic [AddrW-1:0] address;
		logic [ByteW-1:0] dhit;
		logic [ByteW-1:0] bhit;
		logic [RecW-1:0]  record_count;
	} result_t;

	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic int num_w(input int n);
		return $clog2(n + 1);
	endfunction

endpackage

FILE: src/srat_desc_mem.sv
// Segment descriptor memory: one write port, one registered read port.
// Depends on srat_pkg for the descriptor type.
module srat_desc_mem #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                                            clk,
	input  logic                                            we,
	input  logic [srat_pkg::idx_w(TABLE_ENTRIES)-1:0]       waddr,
	input  srat_pkg::desc_t                                 wdata,
	input  logic                                            re,
	input  logic [srat_pkg::idx_w(TABLE_ENTRIES)-1:0]       raddr,
	output srat_pkg::desc_t                                 rdata
);
	import srat_pkg::*;

	desc_t mem [TABLE_ENTRIES];
	desc_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/srat_base_mem.sv
// Block base address memory with per-entry valid bits; unwritten entries read zero.
// Depends on srat_pkg for widths.
module srat_base_mem #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            we,
	input  logic [srat_pkg::idx_w(TABLE_ENTRIES)-1:0]       waddr,
	input  logic [srat_pkg::AddrW-1:0]                      wdata,
	input  logic                                            re,
	input  logic [srat_pkg::idx_w(TABLE_ENTRIES)-1:0]       raddr,
	output logic [srat_pkg::AddrW-1:0]                      rdata
);
	import srat_pkg::*;

	logic [AddrW-1:0]         mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [AddrW-1:0]         rdata_q;
	logic                     rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

FILE: src/srat_xlate.sv
// Control sequencer: decodes each word, runs the binary search over the
// descriptor memory, forms the address and keeps the record count. Uses srat_pkg.
module srat_xlate #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  srat_pkg::cfg_t                                  cfg,
	input  logic                                            in_valid,
	output logic                                            in_stall,
	input  logic [2:0]                                      op,
	input  logic [srat_pkg::ByteW-1:0]                      slot,
	input  logic [srat_pkg::RecW-1:0]                       record_index,
	input  srat_pkg::desc_t                                 in_desc,
	input  logic [srat_pkg::AddrW-1:0]                      in_base,
	output logic                                            desc_we,
	output logic [srat_pkg::idx_w(TABLE_ENTRIES)-1:0]       desc_waddr,
	output srat_pkg::desc_t                                 desc_wdata,
	output logic                                            desc_re,
	output logic [srat_pkg::idx_w(TABLE_ENTRIES)-1:0]       desc_raddr,
	input  srat_pkg::desc_t                                 desc_rdata,
	output logic                                            base_we,
	output logic [srat_pkg::idx_w(TABLE_ENTRIES)-1:0]       base_waddr,
	output logic [srat_pkg::AddrW-1:0]                      base_wdata,
	output logic                                            base_re,
	output logic [srat_pkg::idx_w(TABLE_ENTRIES)-1:0]       base_raddr,
	input  logic [srat_pkg::AddrW-1:0]                      base_rdata,
	input  logic                                            out_free,
	output logic                                            res_valid,
	output srat_pkg::result_t                               res
);
	import srat_pkg::*;

	localparam int IW = idx_w(TABLE_ENTRIES);
	localparam int CW = num_w(TABLE_ENTRIES);
	localparam logic [CntW-1:0] EntriesN = CntW'(TABLE_ENTRIES);

	state_t           state_q, state_nx;
	op_t              op_q;
	status_t          status_q, chk_status;
	logic [RecW-1:0]  idx_q, count_q, count_nx;
	logic [CW-1:0]    lo_q, hi1_q, lo_nx, hi1_nx, mid;
	logic [IW-1:0]    mid_q, hit_q;
	logic [ByteW-1:0] blk_q;
	logic [RecW-1:0]  pos_q;
	logic [AddrW-1:0] offset_q, base_q, addr_q;
	logic [ProdW-1:0] prod_q;
	logic [CntW-1:0]  n_clamp;
	logic             accept, slot_ok, below, above, found, blk_ok;

	assign accept  = in_valid && (state_q == S_IDLE);
	assign slot_ok = {1'b0, slot} < EntriesN;
	assign n_clamp = (cfg.desc_count > EntriesN) ? EntriesN : cfg.desc_count;
	assign mid     = lo_q + ((hi1_q - CW'(1) - lo_q) >> 1);

	assign below  = idx_q < desc_rdata.first;
	assign above  = idx_q > desc_rdata.last;
	assign found  = !below && !above;
	assign blk_ok = ({1'b0, desc_rdata.block} < cfg.block_count) &&
		({1'b0, desc_rdata.block} < EntriesN);
	assign lo_nx  = above ? (CW'(mid_q) + CW'(1)) : lo_q;
	assign hi1_nx = below ? CW'(mid_q) : hi1_q;

	always_comb begin
		chk_status = STS_OK;
		if (idx_q >= cfg.max_records) begin
			chk_status = (op_q == OP_ALLOCATE) ? STS_FULL : STS_RANGE;
		end else if (cfg.desc_count == '0) begin
			chk_status = STS_NODESC;
		end
	end

	always_comb begin
		count_nx = count_q;
		if (op_q == OP_SET_COUNT) begin
			count_nx = idx_q;
		end else if (op_q == OP_ALLOCATE && status_q == STS_OK) begin
			count_nx = count_q + RecW'(1);
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == OP_TRANSLATE || op == OP_ALLOCATE) begin
						state_nx = S_CHECK;
					end else begin
						state_nx = S_DONE;
					end
				end
			end
			S_CHECK: begin
				state_nx = (chk_status == STS_OK) ? S_RD : S_DONE;
			end
			S_RD: begin
				state_nx = S_CMP;
			end
			S_CMP: begin
				if (found) begin
					state_nx = blk_ok ? S_MUL : S_DONE;
				end else if (hi1_nx > lo_nx) begin
					state_nx = S_RD;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_MUL: begin
				state_nx = S_ADD;
			end
			S_ADD: begin
				state_nx = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		desc_we    = 1'b0;
		base_we    = 1'b0;
		desc_re    = 1'b0;
		base_re    = 1'b0;
		res_valid  = 1'b0;
		desc_waddr = slot[IW-1:0];
		base_waddr = slot[IW-1:0];
		desc_wdata = in_desc;
		base_wdata = in_base;
		desc_raddr = mid[IW-1:0];
		base_raddr = desc_rdata.block[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				desc_we  = accept && slot_ok && (op == OP_LOAD_DESC);
				base_we  = accept && slot_ok && (op == OP_LOAD_BASE);
			end
			S_RD: begin
				desc_re = 1'b1;
			end
			S_CMP: begin
				base_re = found && blk_ok;
			end
			S_DONE: begin
				res_valid = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
		res.status       = status_q;
		res.address      = (status_q == STS_OK) ? addr_q : '0;
		res.dhit         = (status_q == STS_OK) ? ByteW'(hit_q) : '0;
		res.bhit         = (status_q == STS_OK) ? blk_q : '0;
		res.record_count = count_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_DONE && out_free) begin
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= op_t'(op);
					idx_q    <= (op == OP_ALLOCATE) ? count_q : record_index;
					status_q <= STS_OK;
					addr_q   <= '0;
					hit_q    <= '0;
					blk_q    <= '0;
				end
			end
			S_CHECK: begin
				status_q <= chk_status;
				lo_q     <= '0;
				hi1_q    <= n_clamp[CW-1:0];
			end
			S_RD: begin
				mid_q <= mid[IW-1:0];
			end
			S_CMP: begin
				if (found) begin
					hit_q    <= mid_q;
					blk_q    <= desc_rdata.block;
					pos_q    <= idx_q - desc_rdata.first;
					offset_q <= desc_rdata.offset;
					if (!blk_ok) begin
						status_q <= STS_NOSEG;
					end
				end else begin
					lo_q  <= lo_nx;
					hi1_q <= hi1_nx;
					if (!(hi1_nx > lo_nx)) begin
						status_q <= STS_NOSEG;
					end
				end
			end
			S_MUL: begin
				prod_q <= pos_q * cfg.record_size;
				base_q <= base_rdata;
			end
			S_ADD: begin
				addr_q <= base_q + offset_q + AddrW'(prod_q);
			end
			default: begin
				addr_q <= addr_q;
			end
		endcase
	end

endmodule

FILE: src/segmented_record_address_translate.sv
// Segmented record address translator, top level; one word is in flight at a time and
// output stalls hold the result back. Loads, set count and unknown ops go straight from
// acceptance to the result word. Translate and allocate stop after the check state if the
// range or descriptor check fails; otherwise binary-search probes of a read and a compare
// state each (at most 5 for 16 entries) follow, then multiply and add on a valid hit.
// Active-low async reset clears count, base valid bits and config; record size resets to 1.
module segmented_record_address_translate #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  slot,
	input  logic [23:0] record_index,
	input  logic [23:0] first_record,
	input  logic [23:0] last_record,
	input  logic [7:0]  block_number,
	input  logic [47:0] offset_or_base,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [47:0] address,
	output logic [7:0]  descriptor_hit,
	output logic [7:0]  block_hit,
	output logic [23:0] record_count
);
	import srat_pkg::*;
	`include "assert_macros.svh"

	localparam int IW = idx_w(TABLE_ENTRIES);

	cfg_t             cfg_q;
	desc_t            in_desc, desc_wdata, desc_rdata;
	logic             desc_we, desc_re, base_we, base_re, res_valid, out_free;
	logic [IW-1:0]    desc_waddr, desc_raddr, base_waddr, base_raddr;
	logic [AddrW-1:0] base_wdata, base_rdata;
	result_t          res, out_q;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_records <= '0;
			cfg_q.record_size <= SizeW'(1);
			cfg_q.desc_count  <= '0;
			cfg_q.block_count <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAX_RECORDS: cfg_q.max_records <= cfg_data;
				REG_RECORD_SIZE: cfg_q.record_size <= cfg_data[SizeW-1:0];
				REG_DESC_COUNT:  cfg_q.desc_count  <= cfg_data[CntW-1:0];
				REG_BLOCK_COUNT: cfg_q.block_count <= cfg_data[CntW-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_desc.first  = first_record;
	assign in_desc.last   = last_record;
	assign in_desc.block  = block_number;
	assign in_desc.offset = offset_or_base;

	srat_xlate #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_xlate (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.slot         (slot),
		.record_index (record_index),
		.in_desc      (in_desc),
		.in_base      (offset_or_base),
		.desc_we      (desc_we),
		.desc_waddr   (desc_waddr),
		.desc_wdata   (desc_wdata),
		.desc_re      (desc_re),
		.desc_raddr   (desc_raddr),
		.desc_rdata   (desc_rdata),
		.base_we      (base_we),
		.base_waddr   (base_waddr),
		.base_wdata   (base_wdata),
		.base_re      (base_re),
		.base_raddr   (base_raddr),
		.base_rdata   (base_rdata),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res          (res)
	);

	srat_desc_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_desc_mem (
		.clk   (clk),
		.we    (desc_we),
		.waddr (desc_waddr),
		.wdata (desc_wdata),
		.re    (desc_re),
		.raddr (desc_raddr),
		.rdata (desc_rdata)
	);

	srat_base_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_base_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (base_we),
		.waddr  (base_waddr),
		.wdata  (base_wdata),
		.re     (base_re),
		.raddr  (base_raddr),
		.rdata  (base_rdata)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign address        = out_q.address;
	assign descriptor_hit = out_q.dhit;
	assign block_hit      = out_q.bhit;
	assign record_count   = out_q.record_count;

	`AST_NEVER(a_no_overwrite, clk, arst_n, res_valid && out_valid_q && out_stall)
	`AST_CHECK(a_busy_after_accept, clk, arst_n, (in_valid && !in_stall) |=> in_stall)
	`AST_CHECK(a_fail_zeroes, clk, arst_n, (out_valid && status != STS_OK) |-> (address == '0 && descriptor_hit == '0 && block_hit == '0))

endmodule

FILE: tb/srat_translate_checker.sv
`timescale 1ns / 1ps
// Result checker for the segmented record address translator: follows the configuration
// port and both word channels, predicts every result word and compares it field by field.
// Depends on srat_pkg for the result layout and the operation, status and register codes.
module srat_translate_checker #(
	parameter int TableEntries = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  slot,
	input  logic [23:0] record_index,
	input  logic [23:0] first_record,
	input  logic [23:0] last_record,
	input  logic [7:0]  block_number,
	input  logic [47:0] offset_or_base,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [47:0] address,
	input  logic [7:0]  descriptor_hit,
	input  logic [7:0]  block_hit,
	input  logic [23:0] record_count,
	output int          mismatch_count,
	output int          words_pending
);
	import srat_pkg::*;

	logic [23:0] limit_records;
	logic [15:0] bytes_per_record;
	logic [8:0]  valid_descriptors;
	logic [8:0]  valid_blocks;
	logic [23:0] seg_first [TableEntries];
	logic [23:0] seg_last [TableEntries];
	logic [7:0]  seg_block [TableEntries];
	logic [47:0] seg_offset [TableEntries];
	logic [47:0] block_base [TableEntries];
	logic [23:0] records_used;
	result_t     expected_words [$];
	int          fails = 0;

	function automatic status_t translate_record(input logic [23:0] idx,
			output logic [47:0] addr, output logic [7:0] dhit, output logic [7:0] bhit);
		int          n;
		int          lo;
		int          hi;
		int          mid;
		int          hit;
		bit          found;
		logic [7:0]  blk;
		logic [23:0] pos;
		logic [47:0] scaled;
		addr = '0;
		dhit = '0;
		bhit = '0;
		hit = 0;
		found = 1'b0;
		if (idx >= limit_records)
			return STS_RANGE;
		n = valid_descriptors;
		if (n < 1)
			return STS_NODESC;
		if (n > TableEntries)
			n = TableEntries;
		if (n == 1) begin
			found = (idx >= seg_first[0]) && (idx <= seg_last[0]);
		end else begin
			lo = 0;
			hi = n - 1;
			while (hi >= lo && !found) begin
				mid = lo + ((hi - lo) >> 1);
				if (idx < seg_first[mid]) begin
					hi = mid - 1;
				end else if (idx > seg_last[mid]) begin
					lo = mid + 1;
				end else begin
					hit = mid;
					found = 1'b1;
				end
			end
		end
		if (!found)
			return STS_NOSEG;
		blk = seg_block[hit];
		if (!(blk < valid_blocks && blk < TableEntries))
			return STS_NOSEG;
		pos = idx - seg_first[hit];
		scaled = 48'(pos) * 48'(bytes_per_record);
		addr = block_base[blk] + seg_offset[hit] + scaled;
		dhit = hit[7:0];
		bhit = blk;
		return STS_OK;
	endfunction

	task automatic check_field(input string name, input logic [47:0] want_v,
			input logic [47:0] got_v);
		if (want_v !== got_v) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		result_t     want;
		result_t     got;
		status_t     sts;
		logic [47:0] addr;
		logic [7:0]  dhit;
		logic [7:0]  bhit;
		if (!arst_n) begin
			limit_records = '0;
			bytes_per_record = 16'd1;
			valid_descriptors = '0;
			valid_blocks = '0;
			records_used = '0;
			for (int i = 0; i < TableEntries; i++) begin
				seg_first[i] = '0;
				seg_last[i] = '0;
				seg_block[i] = '0;
				seg_offset[i] = '0;
				block_base[i] = '0;
			end
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_MAX_RECORDS: limit_records = cfg_data;
				REG_RECORD_SIZE: bytes_per_record = cfg_data[15:0];
				REG_DESC_COUNT:  valid_descriptors = cfg_data[8:0];
				REG_BLOCK_COUNT: valid_blocks = cfg_data[8:0];
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					fails++;
					$display("%0t: result word with none expected, status %0d address %0h",
						$time, status, address);
				end else begin
					want = expected_words.pop_front();
					check_field("status", 48'(want.status), 48'(status));
					check_field("address", want.address, address);
					check_field("descriptor_hit", 48'(want.dhit), 48'(descriptor_hit));
					check_field("block_hit", 48'(want.bhit), 48'(block_hit));
					check_field("record_count", 48'(want.record_count), 48'(record_count));
				end
			end
			if (in_valid && !in_stall) begin
				sts = STS_OK;
				addr = '0;
				dhit = '0;
				bhit = '0;
				case (op)
				OP_LOAD_DESC: begin
					if (slot < TableEntries) begin
						seg_first[slot] = first_record;
						seg_last[slot] = last_record;
						seg_block[slot] = block_number;
						seg_offset[slot] = offset_or_base;
					end
				end
				OP_LOAD_BASE: begin
					if (slot < TableEntries)
						block_base[slot] = offset_or_base;
				end
				OP_TRANSLATE: sts = translate_record(record_index, addr, dhit, bhit);
				OP_ALLOCATE: begin
					if (records_used >= limit_records) begin
						sts = STS_FULL;
					end else begin
						sts = translate_record(records_used, addr, dhit, bhit);
						if (sts == STS_OK)
							records_used = records_used + 24'd1;
					end
				end
				OP_SET_COUNT: records_used = record_index;
				default: ;
				endcase
				if (sts != STS_OK) begin
					addr = '0;
					dhit = '0;
					bhit = '0;
				end
				got.status = sts;
				got.address = addr;
				got.dhit = dhit;
				got.bhit = bhit;
				got.record_count = records_used;
				expected_words.push_back(got);
			end
		end
		words_pending <= expected_words.size();
		mismatch_count <= fails;
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the segmented record address translator testbench: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on srat_pkg, the block and srat_translate_checker.
module tb_top;
	import srat_pkg::*;

	localparam int TableEntries = 16;
	localparam int CycleLimit = 400000;
	localparam logic [23:0] RecMax = 24'hFF_FFFF;
	localparam logic [47:0] AddrMax = 48'hFFFF_FFFF_FFFF;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = '0;
	logic [7:0]  slot = '0;
	logic [23:0] record_index = '0;
	logic [23:0] first_record = '0;
	logic [23:0] last_record = '0;
	logic [7:0]  block_number = '0;
	logic [47:0] offset_or_base = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [47:0] address;
	logic [7:0]  descriptor_hit;
	logic [7:0]  block_hit;
	logic [23:0] record_count;
	int          mismatches;
	int          pending;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	logic [23:0] cur_max = '0;
	int unsigned lay_first [TableEntries];
	int unsigned lay_last [TableEntries];

	segmented_record_address_translate #(
		.TABLE_ENTRIES(TableEntries)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .slot(slot), .record_index(record_index),
		.first_record(first_record), .last_record(last_record),
		.block_number(block_number), .offset_or_base(offset_or_base),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .address(address), .descriptor_hit(descriptor_hit),
		.block_hit(block_hit), .record_count(record_count)
	);

	srat_translate_checker #(
		.TableEntries(TableEntries)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .slot(slot), .record_index(record_index),
		.first_record(first_record), .last_record(last_record),
		.block_number(block_number), .offset_or_base(offset_or_base),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .address(address), .descriptor_hit(descriptor_hit),
		.block_hit(block_hit), .record_count(record_count),
		.mismatch_count(mismatches), .words_pending(pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	function automatic logic [23:0] rand24();
		return $urandom_range(RecMax);
	endfunction

	function automatic logic [47:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[47:0];
	endfunction

	function automatic logic [23:0] pick_index();
		int          s;
		int unsigned v;
		s = $urandom_range(TableEntries - 1);
		case ($urandom_range(9))
		0, 1: v = lay_first[s];
		2, 3: v = lay_last[s];
		4: v = lay_last[s] + 1;
		5: v = lay_first[s] - 1;
		default: v = $urandom_range(lay_last[s], lay_first[s]);
		endcase
		return v[23:0];
	endfunction

	task automatic send_word(input logic [2:0] code, input logic [7:0] slot_v,
			input logic [23:0] idx_v, input logic [23:0] first_v, input logic [23:0] last_v,
			input logic [7:0] blk_v, input logic [47:0] ob_v);
		in_valid <= 1'b1;
		op <= code;
		slot <= slot_v;
		record_index <= idx_v;
		first_record <= first_v;
		last_record <= last_v;
		block_number <= blk_v;
		offset_or_base <= ob_v;
		do @(posedge clk); while (in_stall);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic send_op(input logic [2:0] code, input logic [23:0] idx_v);
		send_word(code, $urandom_range(255), idx_v, rand24(), rand24(), $urandom_range(255),
			rand48());
	endtask

	task automatic load_descriptor(input logic [7:0] slot_v, input logic [23:0] first_v,
			input logic [23:0] last_v, input logic [7:0] blk_v, input logic [47:0] ofs_v);
		if (slot_v < TableEntries) begin
			lay_first[slot_v] = first_v;
			lay_last[slot_v] = last_v;
		end
		send_word(OP_LOAD_DESC, slot_v, rand24(), first_v, last_v, blk_v, ofs_v);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t which, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (which == REG_MAX_RECORDS)
			cur_max = val;
	endtask

	task automatic build_table(input int mode);
		int unsigned cur;
		int unsigned len;
		int unsigned shift;
		int unsigned firsts [TableEntries];
		int unsigned lasts [TableEntries];
		logic [7:0]  blk;
		logic [47:0] ofs;
		cur = (mode == 0) ? 0 : $urandom_range(1000);
		for (int i = 0; i < TableEntries; i++) begin
			len = (mode == 0) ? $urandom_range(32, 1) : $urandom_range(50000, 1);
			firsts[i] = cur;
			lasts[i] = cur + len - 1;
			cur = lasts[i] + 1 + ((mode == 0) ? $urandom_range(4) : $urandom_range(50000));
		end
		shift = (mode == 2) ? RecMax - lasts[TableEntries - 1] : 0;
		for (int i = 0; i < TableEntries; i++) begin
			blk = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(15);
			ofs = ($urandom_range(7) == 0) ? AddrMax : rand48();
			load_descriptor(i, firsts[i] + shift, lasts[i] + shift, blk, ofs);
		end
		for (int b = 0; b < TableEntries; b++)
			send_word(OP_LOAD_BASE, b, rand24(), rand24(), rand24(), $urandom_range(255),
				($urandom_range(7) == 0) ? AddrMax : rand48());
	endtask

	task automatic configure_phase(input int p);
		logic [23:0] lim;
		logic [15:0] sz;
		logic [8:0]  nd;
		logic [8:0]  nb;
		lim = RecMax;
		sz = $urandom_range(16'hFFFF, 1);
		nd = TableEntries;
		nb = TableEntries;
		case (p)
		1: begin
			sz = 16'hFFFF;
			nd = 9'd256;
			nb = 9'd256;
		end
		2: begin
			lim = $urandom_range(RecMax);
			nd = $urandom_range(15, 2);
			nb = $urandom_range(16);
		end
		3: begin
			lim = lay_last[7];
			nb = 9'd8;
		end
		4: nd = 9'd1;
		5: begin
			nd = $urandom_range(256, 9);
			nb = $urandom_range(255);
		end
		6: lim = lay_first[3];
		7: sz = 16'hFFFF;
		default: sz = 16'd1;
		endcase
		write_reg(REG_MAX_RECORDS, lim);
		write_reg(REG_RECORD_SIZE, sz);
		write_reg(REG_DESC_COUNT, nd);
		write_reg(REG_BLOCK_COUNT, nb);
	endtask

	task automatic random_item();
		int          r;
		int          s;
		logic [7:0]  slot_v;
		logic [23:0] cnt;
		r = $urandom_range(99);
		s = $urandom_range(TableEntries - 1);
		if (r < 40) begin
			send_op(OP_TRANSLATE, ($urandom_range(4) == 0) ? rand24() : pick_index());
		end else if (r < 60) begin
			send_op(OP_ALLOCATE, rand24());
		end else if (r < 68) begin
			case ($urandom_range(3))
			0: cnt = '0;
			1: cnt = rand24();
			2: cnt = cur_max - 24'd1;
			default: cnt = pick_index();
			endcase
			send_op(OP_SET_COUNT, cnt);
		end else if (r < 78) begin
			if ($urandom_range(3) == 0) begin
				slot_v = ($urandom_range(1) == 0) ? $urandom_range(255) : s;
				load_descriptor(slot_v, rand24(), rand24(), $urandom_range(255), rand48());
			end else begin
				load_descriptor(s, lay_first[s], lay_last[s], $urandom_range(15), rand48());
			end
		end else if (r < 88) begin
			slot_v = ($urandom_range(4) == 0) ? $urandom_range(255) : s;
			send_word(OP_LOAD_BASE, slot_v, rand24(), rand24(), rand24(), $urandom_range(255),
				($urandom_range(7) == 0) ? AddrMax : rand48());
		end else if (r < 95) begin
			send_op(OP_SET_COUNT, ($urandom_range(1) == 0) ? lay_first[s] : pick_index());
			repeat ($urandom_range(5, 1))
				send_op(OP_ALLOCATE, rand24());
		end else begin
			send_op($urandom_range(OP_SPARE_HI, OP_SPARE_LO), rand24());
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of range with the reset limit, then allocation when full and spare codes.
		send_op(OP_TRANSLATE, '0);
		send_op(OP_ALLOCATE, rand24());
		for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
			send_op(c, rand24());
		send_op(OP_SET_COUNT, RecMax);
		send_op(OP_SET_COUNT, '0);
		drain_results();
		write_reg(REG_MAX_RECORDS, RecMax);
		send_op(OP_TRANSLATE, RecMax - 24'd1);
		send_op(OP_ALLOCATE, rand24());

		build_table(0);
		load_descriptor(8'hFF, rand24(), rand24(), $urandom_range(255), rand48());
		send_word(OP_LOAD_BASE, TableEntries, rand24(), rand24(), rand24(), '0, AddrMax);

		// A single descriptor is checked directly; a zero record size adds nothing.
		drain_results();
		write_reg(REG_DESC_COUNT, 24'd1);
		write_reg(REG_BLOCK_COUNT, TableEntries);
		write_reg(REG_RECORD_SIZE, '0);
		send_op(OP_TRANSLATE, lay_first[0]);
		send_op(OP_TRANSLATE, lay_last[0]);
		send_op(OP_TRANSLATE, lay_last[0] + 1);

		drain_results();
		write_reg(REG_DESC_COUNT, 24'd256);
		write_reg(REG_BLOCK_COUNT, 24'd256);
		write_reg(REG_RECORD_SIZE, 24'hFFFF);
		send_op(OP_TRANSLATE, RecMax);
		send_op(OP_TRANSLATE, lay_first[0]);
		send_op(OP_TRANSLATE, lay_last[TableEntries - 1]);
		send_op(OP_TRANSLATE, lay_last[3] + 1);
		send_op(OP_SET_COUNT, lay_last[0]);
		send_op(OP_ALLOCATE, rand24());
		send_op(OP_ALLOCATE, rand24());
		load_descriptor(8'd2, lay_first[2], lay_last[2], 8'hFF, rand48());
		send_op(OP_TRANSLATE, lay_first[2]);
		send_word(OP_LOAD_BASE, 8'd5, rand24(), rand24(), rand24(), '0, AddrMax);
		load_descriptor(8'd5, lay_first[5], lay_last[5], 8'd5, AddrMax);
		send_op(OP_TRANSLATE, lay_last[5]);
		send_op(OP_SET_COUNT, RecMax);
		send_op(OP_ALLOCATE, rand24());

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 55;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 55;
			end
			default: begin
				send_idle_pct = 23;
				stall_pct = 23;
			end
			endcase
			build_table(p % 3);
			drain_results();
			configure_phase(p);
			repeat (120)
				random_item();
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (30) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
